[src/fcs_pkg.sv]
// Shared types and constants for the cylindrical Fresnel scale block.
`timescale 1ns / 1ps
package fcs_pkg;

  // Fixed-point one and a quarter turn in Q1.30.
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // Odd Taylor series in Horner form, innermost divisor first.
  localparam int HORNER_STEPS = 5;
  localparam logic [6:0] HORNER_DIV [HORNER_STEPS] = '{
    7'd110, 7'd72, 7'd42, 7'd20, 7'd6
  };
  // Reciprocals floor(2^32 / d); the quotient estimate is low by at most one.
  localparam logic [29:0] HORNER_RECIP [HORNER_STEPS] = '{
    30'(64'h1_0000_0000 / 64'd110),
    30'(64'h1_0000_0000 / 64'd72),
    30'(64'h1_0000_0000 / 64'd42),
    30'(64'h1_0000_0000 / 64'd20),
    30'(64'h1_0000_0000 / 64'd6)
  };

  // Sine pipeline: angle scale, square, three stages per step, final product.
  localparam int SIN_LAT = 2 + 3 * HORNER_STEPS + 1;

  // Quotient and root widths of the back end.
  localparam int DIV_BITS  = 80;
  localparam int ROOT_BITS = 40;
  localparam logic [39:0] OUT_MAX = 40'hFF_FFFF_FFFF;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified item as it leaves the front end.
  typedef struct packed {
    logic [31:0] wavelength;
    logic [31:0] distance;
    logic [14:0] sin_open;   // folded angle for |sin B|
    logic [14:0] cos_open;   // folded angle for |cos B|
    logic [14:0] sin_azim;   // folded angle for |sin phi|
    logic        zero_open;  // sin B is exactly zero
  } fcs_item_t;

endpackage

[src/fcs_front.sv]
// Front end: takes input beats and folds the angles into a quarter wave.
`timescale 1ns / 1ps
module fcs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [31:0]       wavelength_i,
  input  logic [31:0]       distance_i,
  input  logic [15:0]       azimuth_angle_i,
  input  logic [15:0]       opening_angle_i,
  output logic              push_valid_o,
  output fcs_pkg::fcs_item_t push_item_o,
  input  logic              push_ready_i
);
  import fcs_pkg::*;

  logic      vld_q;
  fcs_item_t item_q;
  fcs_item_t item_d;
  logic      take;

  // Map a binary angle onto 0..16384 within the first quarter wave.
  function automatic logic [14:0] fold(input logic [15:0] a);
    logic [14:0] r;
    r = {1'b0, a[13:0]};
    if (a[14]) begin
      r = 15'd16384 - r;
    end
    return r;
  endfunction

  assign in_ready_o   = !vld_q || push_ready_i;
  assign take         = in_valid_i && in_ready_o;
  assign push_valid_o = vld_q;
  assign push_item_o  = item_q;

  // Classify the beat: folded angles and the zero-opening case.
  always_comb begin
    item_d.wavelength = wavelength_i;
    item_d.distance   = distance_i;
    item_d.sin_open   = fold(opening_angle_i);
    item_d.cos_open   = fold(16'(opening_angle_i + 16'd16384));
    item_d.sin_azim   = fold(azimuth_angle_i);
    item_d.zero_open  = (fold(opening_angle_i) == 15'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule

[src/fcs_queue.sv]
// Short queue that decouples the front end from the back end.
`timescale 1ns / 1ps
module fcs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  fcs_pkg::fcs_item_t push_item_i,
  output logic              push_ready_o,
  output logic              pop_valid_o,
  output fcs_pkg::fcs_item_t pop_item_o,
  input  logic              pop_ready_i
);
  import fcs_pkg::*;

  fcs_item_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q;
  logic [QPTR_W-1:0]  rd_ptr_q;
  logic [QCNT_W-1:0]  cnt_q;
  logic               push;
  logic               pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count above depth");

endmodule

[src/fcs_sine.sv]
// Pipelined |sin| of a folded binary angle, Q1.30, by a Horner-form series.
`timescale 1ns / 1ps
module fcs_sine (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [14:0] angle_i,
  output logic [30:0] sine_o
);
  import fcs_pkg::*;

  logic [30:0] x0_q;
  logic [30:0] x1_q;
  logic [31:0] xsq_q;

  // Per step: multiply stage (a), reciprocal stage (b), correction stage (c).
  logic [62:0] am_q  [HORNER_STEPS];
  logic [30:0] ax_q  [HORNER_STEPS];
  logic [31:0] axs_q [HORNER_STEPS];
  logic [31:0] bv_q  [HORNER_STEPS];
  logic [61:0] bp_q  [HORNER_STEPS];
  logic [30:0] bx_q  [HORNER_STEPS];
  logic [31:0] bxs_q [HORNER_STEPS];
  logic [30:0] ct_q  [HORNER_STEPS];
  logic [30:0] cx_q  [HORNER_STEPS];
  logic [31:0] cxs_q [HORNER_STEPS];
  logic [30:0] ct_d  [HORNER_STEPS];
  logic [30:0] sine_q;

  logic [45:0] xp;
  logic [61:0] xx;
  logic [61:0] fp;
  logic [31:0] fs;

  assign xp = 46'(angle_i) * 46'(HALF_PI_Q30);
  assign xx = 62'(x0_q) * 62'(x0_q);
  assign fp = 62'(cx_q[HORNER_STEPS-1]) * 62'(ct_q[HORNER_STEPS-1]);
  assign fs = fp[61:30];

  // Correction of the reciprocal estimate: one compare, then t = 1 - q.
  always_comb begin
    logic [29:0] q0;
    logic [31:0] r;
    logic [30:0] q;
    for (int k = 0; k < HORNER_STEPS; k++) begin
      q0      = bp_q[k][61:32];
      r       = bv_q[k] - 32'(q0) * 32'(HORNER_DIV[k]);
      q       = 31'(q0) + 31'(r >= 32'(HORNER_DIV[k]));
      ct_d[k] = ONE_Q30 - q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Angle in radians and its square.
      x0_q  <= xp[44:14];
      x1_q  <= x0_q;
      xsq_q <= xx[61:30];
      for (int k = 0; k < HORNER_STEPS; k++) begin
        if (k == 0) begin
          am_q[k]  <= 63'(xsq_q) * 63'(ONE_Q30);
          ax_q[k]  <= x1_q;
          axs_q[k] <= xsq_q;
        end else begin
          am_q[k]  <= 63'(cxs_q[k-1]) * 63'(ct_q[k-1]);
          ax_q[k]  <= cx_q[k-1];
          axs_q[k] <= cxs_q[k-1];
        end
        bv_q[k]  <= am_q[k][61:30];
        bp_q[k]  <= 62'(am_q[k][61:30]) * 62'(HORNER_RECIP[k]);
        bx_q[k]  <= ax_q[k];
        bxs_q[k] <= axs_q[k];
        ct_q[k]  <= ct_d[k];
        cx_q[k]  <= bx_q[k];
        cxs_q[k] <= bxs_q[k];
      end
      // Outer factor x, clamped to one.
      sine_q <= (fs > 32'(ONE_Q30)) ? ONE_Q30 : fs[30:0];
    end
  end

  assign sine_o = sine_q;

endmodule

[src/fcs_back.sv]
// Back end: sines, products, pipelined divider and square root, output register.
`timescale 1ns / 1ps
module fcs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  fcs_pkg::fcs_item_t in_item_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [39:0]       fresnel_scale_o,
  output logic              zero_opening_error_o
);
  import fcs_pkg::*;

  logic        adv;
  logic        take;
  logic        out_valid_q;
  logic [39:0] fresnel_q;
  logic        zero_q;

  // Side line that runs next to the sine pipelines.
  logic [SIN_LAT-1:0] sv_q;
  logic [31:0]        slam_q  [SIN_LAT];
  logic [31:0]        sdist_q [SIN_LAT];
  logic               szero_q [SIN_LAT];
  logic [30:0]        sb;
  logic [30:0]        cb;
  logic [30:0]        sp;

  // Product stages.
  logic [4:0]  pv_q;
  logic [30:0] cp_q;
  logic [60:0] sb2_q;
  logic [63:0] ld1_q;
  logic [63:0] ld2_q;
  logic [30:0] u_q;
  logic [61:0] den2_q;
  logic [61:0] den3_q;
  logic [61:0] den4_q;
  logic [62:0] mh_q;
  logic [62:0] ml_q;
  logic [94:0] pn_q;
  logic        z1_q, z2_q, z3_q, z4_q;
  logic [61:0] cc;
  logic [61:0] cpsq;
  logic [61:0] sbsq;

  // Division seed.
  logic        z5_q;
  logic        o5_q;
  logic [61:0] r5_q;
  logic [33:0] l5_q;
  logic [61:0] den5_q;

  // Divider stages, one quotient bit each.
  logic [DIV_BITS-1:0] dv_q;
  logic [61:0]         dr_q [DIV_BITS];
  logic [33:0]         dl_q [DIV_BITS];
  logic [79:0]         dq_q [DIV_BITS];
  logic [61:0]         dd_q [DIV_BITS];
  logic                dz_q [DIV_BITS];
  logic                do_q [DIV_BITS];
  logic [61:0]         dr_d [DIV_BITS];
  logic [33:0]         dl_d [DIV_BITS];
  logic [79:0]         dq_d [DIV_BITS];

  // Root stages, one root bit each.
  logic [ROOT_BITS-1:0] rv_q;
  logic [41:0]          rr_q [ROOT_BITS];
  logic [39:0]          ry_q [ROOT_BITS];
  logic [79:0]          rq_q [ROOT_BITS];
  logic                 rz_q [ROOT_BITS];
  logic                 ro_q [ROOT_BITS];
  logic [41:0]          rr_d [ROOT_BITS];
  logic [39:0]          ry_d [ROOT_BITS];

  // The whole back end moves together when the output register can load.
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign take       = in_valid_i && adv;

  fcs_sine u_sin_open (
    .clk_i  (clk_i),
    .en_i   (adv),
    .angle_i(in_item_i.sin_open),
    .sine_o (sb)
  );

  fcs_sine u_cos_open (
    .clk_i  (clk_i),
    .en_i   (adv),
    .angle_i(in_item_i.cos_open),
    .sine_o (cb)
  );

  fcs_sine u_sin_azim (
    .clk_i  (clk_i),
    .en_i   (adv),
    .angle_i(in_item_i.sin_azim),
    .sine_o (sp)
  );

  assign cc   = 62'(cb) * 62'(sp);
  assign sbsq = 62'(sb) * 62'(sb);
  assign cpsq = 62'(cp_q) * 62'(cp_q);

  // One quotient bit per stage: shift in the next dividend bit, try a subtract.
  always_comb begin
    logic [62:0] rs;
    logic [61:0] pr;
    logic [33:0] pl;
    logic [79:0] pq;
    logic [61:0] pd;
    logic        bit_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      if (i == 0) begin
        pr = r5_q;
        pl = l5_q;
        pq = '0;
        pd = den5_q;
      end else begin
        pr = dr_q[i-1];
        pl = dl_q[i-1];
        pq = dq_q[i-1];
        pd = dd_q[i-1];
      end
      rs    = {pr, pl[33]};
      bit_q = (rs >= {1'b0, pd});
      dr_d[i] = bit_q ? 62'(rs - {1'b0, pd}) : rs[61:0];
      dl_d[i] = {pl[32:0], 1'b0};
      dq_d[i] = {pq[78:0], bit_q};
    end
  end

  // One root bit per stage, two radicand bits consumed each time.
  always_comb begin
    logic [43:0] rs;
    logic [43:0] trial;
    logic [41:0] pr;
    logic [39:0] py;
    logic [79:0] pq;
    for (int j = 0; j < ROOT_BITS; j++) begin
      if (j == 0) begin
        pr = '0;
        py = '0;
        pq = dq_q[DIV_BITS-1];
      end else begin
        pr = rr_q[j-1];
        py = ry_q[j-1];
        pq = rq_q[j-1];
      end
      rs    = {pr, pq[79:78]};
      trial = {2'b00, py, 2'b01};
      if (rs >= trial) begin
        rr_d[j] = 42'(rs - trial);
        ry_d[j] = {py[38:0], 1'b1};
      end else begin
        rr_d[j] = rs[41:0];
        ry_d[j] = {py[38:0], 1'b0};
      end
    end
  end

  // Valid bits of every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q        <= '0;
      pv_q        <= '0;
      dv_q        <= '0;
      rv_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      sv_q        <= {sv_q[SIN_LAT-2:0], take};
      pv_q        <= {pv_q[3:0], sv_q[SIN_LAT-1]};
      dv_q        <= {dv_q[DIV_BITS-2:0], pv_q[4]};
      rv_q        <= {rv_q[ROOT_BITS-2:0], dv_q[DIV_BITS-1]};
      out_valid_q <= rv_q[ROOT_BITS-1];
    end
  end

  // Payload of every stage.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      slam_q[0]  <= in_item_i.wavelength;
      sdist_q[0] <= in_item_i.distance;
      szero_q[0] <= in_item_i.zero_open;
      for (int i = 1; i < SIN_LAT; i++) begin
        slam_q[i]  <= slam_q[i-1];
        sdist_q[i] <= sdist_q[i-1];
        szero_q[i] <= szero_q[i-1];
      end

      // cos B * sin phi, sin^2 B and wavelength * distance.
      cp_q  <= cc[60:30];
      sb2_q <= sbsq[60:0];
      ld1_q <= 64'(slam_q[SIN_LAT-1]) * 64'(sdist_q[SIN_LAT-1]);
      z1_q  <= szero_q[SIN_LAT-1];

      // u = 1 - (cos B sin phi)^2 and the denominator 2 sin^2 B.
      u_q    <= ONE_Q30 - cpsq[60:30];
      den2_q <= {sb2_q, 1'b0};
      ld2_q  <= ld1_q;
      z2_q   <= z1_q;

      // Numerator in two halves.
      mh_q   <= 63'(ld2_q[63:32]) * 63'(u_q);
      ml_q   <= 63'(ld2_q[31:0]) * 63'(u_q);
      den3_q <= den2_q;
      z3_q   <= z2_q;

      pn_q   <= {mh_q[62:0], 32'h0} + 95'(ml_q);
      den4_q <= den3_q;
      z4_q   <= z3_q;

      // Overflow when the quotient would need more than its bits.
      o5_q   <= ({1'b0, pn_q} >= {den4_q, 34'h0});
      r5_q   <= {1'b0, pn_q[94:34]};
      l5_q   <= pn_q[33:0];
      den5_q <= den4_q;
      z5_q   <= z4_q;

      for (int i = 0; i < DIV_BITS; i++) begin
        dr_q[i] <= dr_d[i];
        dl_q[i] <= dl_d[i];
        dq_q[i] <= dq_d[i];
        dd_q[i] <= (i == 0) ? den5_q : dd_q[i-1];
        dz_q[i] <= (i == 0) ? z5_q : dz_q[i-1];
        do_q[i] <= (i == 0) ? o5_q : do_q[i-1];
      end

      for (int j = 0; j < ROOT_BITS; j++) begin
        rr_q[j] <= rr_d[j];
        ry_q[j] <= ry_d[j];
        if (j == 0) begin
          rq_q[j] <= {dq_q[DIV_BITS-1][77:0], 2'b00};
          rz_q[j] <= dz_q[DIV_BITS-1];
          ro_q[j] <= do_q[DIV_BITS-1];
        end else begin
          rq_q[j] <= {rq_q[j-1][77:0], 2'b00};
          rz_q[j] <= rz_q[j-1];
          ro_q[j] <= ro_q[j-1];
        end
      end

      // Saturate on a zero opening angle or a quotient overflow.
      fresnel_q <= (rz_q[ROOT_BITS-1] || ro_q[ROOT_BITS-1]) ? OUT_MAX
                                                            : ry_q[ROOT_BITS-1];
      zero_q    <= rz_q[ROOT_BITS-1];
    end
  end

  assign out_valid_o          = out_valid_q;
  assign fresnel_scale_o      = fresnel_q;
  assign zero_opening_error_o = zero_q;

  a_zero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && zero_q |-> fresnel_q == OUT_MAX)
    else $error("zero opening beat without saturated scale");

  // A quotient that neither overflows nor comes from a zero opening ends with a remainder below the denominator.
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[DIV_BITS-1] && !dz_q[DIV_BITS-1] && !do_q[DIV_BITS-1]
      |-> dr_q[DIV_BITS-1] < dd_q[DIV_BITS-1])
    else $error("divider remainder not below denominator");

  a_root_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q[ROOT_BITS-1] |-> rr_q[ROOT_BITS-1] <= {1'b0, ry_q[ROOT_BITS-1], 1'b0})
    else $error("root remainder above twice the root");

endmodule

[src/cylindrical_fresnel_scale.sv]
// Top level of the cylindrical Fresnel scale block.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid_i/ready_o   wavelength, distance, azimuth, opening angle
//   out      output     out_valid_o/ready_i  fresnel_scale, zero_opening_error
//
// One beat is accepted per cycle and one result leaves per cycle while the output is not
// stalled. The back end is a fully pipelined chain: the 80-stage divider and the 40-stage
// square root, one bit per stage, behind the 18-stage sine pipelines.
// Reset clears only valid bits, queue pointers and the fill count; payload registers are not reset.
// A stalled output freezes the whole back end; the queue and the front register keep
// taking beats until they fill.
`timescale 1ns / 1ps
module cylindrical_fresnel_scale (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] wavelength_i,
  input  logic [31:0] distance_i,
  input  logic [15:0] azimuth_angle_i,
  input  logic [15:0] opening_angle_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [39:0] fresnel_scale_o,
  output logic        zero_opening_error_o
);
  import fcs_pkg::*;

  logic      push_valid;
  logic      push_ready;
  fcs_item_t push_item;
  logic      pop_valid;
  logic      pop_ready;
  fcs_item_t pop_item;

  // Front end: accept and classify.
  fcs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .wavelength_i   (wavelength_i),
    .distance_i     (distance_i),
    .azimuth_angle_i(azimuth_angle_i),
    .opening_angle_i(opening_angle_i),
    .push_valid_o   (push_valid),
    .push_item_o    (push_item),
    .push_ready_i   (push_ready)
  );

  // Queue between the two halves.
  fcs_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_item_i (push_item),
    .push_ready_o(push_ready),
    .pop_valid_o (pop_valid),
    .pop_item_o  (pop_item),
    .pop_ready_i (pop_ready)
  );

  // Back end: arithmetic pipeline and output register.
  fcs_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (pop_valid),
    .in_item_i           (pop_item),
    .in_ready_o          (pop_ready),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .fresnel_scale_o     (fresnel_scale_o),
    .zero_opening_error_o(zero_opening_error_o)
  );

endmodule
